FILE: rtl/core/vjb_pkg.sv
// Shared constants, codes and control types of the voice jitter buffer.
package vjb_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int SEQ_BITS        = 31;
    localparam int LAST_BITS       = 32;
    localparam int OFF_BITS        = 34;
    localparam int STATUS_BITS     = 2;
    localparam int SAT_BITS        = 16;
    localparam int FILL_BITS       = 7;
    localparam int EXCESS_BITS     = 32;
    localparam int MAX_FILL_BITS   = 7;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 7;

    localparam logic [MAX_FILL_BITS-1:0] MAX_FILL_RESET = 7'd64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FILL = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRETCH  = 4'd1;

    localparam logic [STATUS_BITS-1:0] ST_APPENDED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REPAIRED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_REJECTED = 2'd2;

    typedef struct packed {
        logic load;
        logic offs;
        logic classify;
        logic fin;
        logic drop;
        logic keep;
        logic pop;
        logic ptr;
        logic gap_wr;
        logic app_wr;
        logic tchk;
        logic walk_wr;
        logic fix_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic off_pos;
        logic fin_zero;
        logic g_zero;
        logic tgt_neg;
        logic stretch;
        logic walk_more;
        logic rd_valid;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/core/vjb_ifs.sv
// Channel interfaces of the voice jitter buffer: packet input, result output, configuration.
interface vjb_pkt_if #(
    parameter int HANDLE_BITS = vjb_pkg::HANDLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [vjb_pkg::SEQ_BITS-1:0]  sequence_number;
    logic [HANDLE_BITS-1:0]        packet_handle;

    modport source (output valid, output sequence_number, output packet_handle, input ready);
    modport sink   (input valid, input sequence_number, input packet_handle, output ready);
endinterface

interface vjb_res_if;
    logic                             valid;
    logic                             ready;
    logic [vjb_pkg::STATUS_BITS-1:0]  status;
    logic [vjb_pkg::SAT_BITS-1:0]     gap_fills;
    logic [vjb_pkg::SAT_BITS-1:0]     dropped_now;
    logic [vjb_pkg::FILL_BITS-1:0]    fill_level;
    logic [vjb_pkg::EXCESS_BITS-1:0]  excess_total;

    modport source (output valid, output status, output gap_fills, output dropped_now,
                    output fill_level, output excess_total, input ready);
    modport sink   (input valid, input status, input gap_fills, input dropped_now,
                    input fill_level, input excess_total, output ready);
endinterface

interface vjb_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vjb_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [vjb_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/vjb_ram.sv
// Generic simple dual-port RAM with registered read data.
module vjb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/vjb_ctrl.sv
// Sequencing state machine of the jitter buffer: append, gap fill, overflow pop and repair walk.
module vjb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  vjb_pkg::sts_t sts,
    output vjb_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFFS  = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_FIN   = 4'd3;
    localparam logic [3:0] S_DROP  = 4'd4;
    localparam logic [3:0] S_KEEP  = 4'd5;
    localparam logic [3:0] S_POP   = 4'd6;
    localparam logic [3:0] S_PTR   = 4'd7;
    localparam logic [3:0] S_GAP   = 4'd8;
    localparam logic [3:0] S_APP   = 4'd9;
    localparam logic [3:0] S_TCHK  = 4'd10;
    localparam logic [3:0] S_WRD   = 4'd11;
    localparam logic [3:0] S_WCHK  = 4'd12;
    localparam logic [3:0] S_FIX   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_OFFS;
                end
            end
            S_OFFS:
            begin
                cmd.offs   = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = sts.off_pos ? S_FIN : S_TCHK;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DROP;
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_KEEP;
            end
            S_KEEP:
            begin
                cmd.keep   = 1'b1;
                state_next = sts.fin_zero ? S_DONE : S_POP;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_PTR;
            end
            S_PTR:
            begin
                cmd.ptr    = 1'b1;
                state_next = S_GAP;
            end
            S_GAP:
            begin
                if (sts.g_zero)
                begin
                    state_next = S_APP;
                end
                else
                begin
                    cmd.gap_wr = 1'b1;
                end
            end
            S_APP:
            begin
                cmd.app_wr = 1'b1;
                state_next = S_DONE;
            end
            S_TCHK:
            begin
                cmd.tchk = 1'b1;
                priority if (sts.tgt_neg)
                begin
                    state_next = S_DONE;
                end
                else if (sts.stretch)
                begin
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = S_FIX;
                end
            end
            S_WRD:
            begin
                if (sts.walk_more)
                begin
                    state_next = S_WCHK;
                end
                else
                begin
                    state_next = S_FIX;
                end
            end
            S_WCHK:
            begin
                if (sts.rd_valid)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cmd.walk_wr = 1'b1;
                    state_next  = S_WRD;
                end
            end
            S_FIX:
            begin
                cmd.fix_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/vjb_dp.sv
// Datapath of the jitter buffer: ring pointers, sequence arithmetic, counters, entry store, result register.
module vjb_dp #(
    parameter int CAPACITY    = vjb_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = vjb_pkg::HANDLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vjb_pkg::cmd_t                        cmd,
    output vjb_pkg::sts_t                        sts,
    input  logic                                 cfg_we,
    input  logic [vjb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vjb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [vjb_pkg::SEQ_BITS-1:0]         seq_in,
    input  logic [HANDLE_BITS-1:0]               handle_in,
    input  logic                                 res_ready,
    output logic                                 res_valid,
    output logic [vjb_pkg::STATUS_BITS-1:0]      res_status,
    output logic [vjb_pkg::SAT_BITS-1:0]         res_gap_fills,
    output logic [vjb_pkg::SAT_BITS-1:0]         res_dropped_now,
    output logic [vjb_pkg::FILL_BITS-1:0]        res_fill_level,
    output logic [vjb_pkg::EXCESS_BITS-1:0]      res_excess_total
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = CW + 1;
    localparam int EW  = HANDLE_BITS + 2;
    localparam int OW  = vjb_pkg::OFF_BITS;
    localparam int LW  = vjb_pkg::LAST_BITS;
    localparam int XW  = vjb_pkg::EXCESS_BITS;
    localparam int MW  = vjb_pkg::MAX_FILL_BITS;
    localparam int SB  = vjb_pkg::SAT_BITS;

    localparam logic [EW-1:0] FILL_MASK = {1'b1, 1'b0, {HANDLE_BITS{1'b1}}};
    localparam logic [OW-1:0] SAT_MAX   = OW'((64'd1 << SB) - 64'd1);
    localparam logic [XW:0]   EXC_MAX   = {1'b0, {XW{1'b1}}};

    function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
        return t[IW-1:0];
    endfunction

    function automatic logic [SB-1:0] sat16(input logic [OW-1:0] v);
        return (v > SAT_MAX) ? {SB{1'b1}} : v[SB-1:0];
    endfunction

    // control state
    logic [MW-1:0]  max_fill_reg, max_fill_next;
    logic           stretch_reg, stretch_next;
    logic [IW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [LW-1:0]  last_reg, last_next;
    logic           primed_reg, primed_next;
    logic [XW-1:0]  excess_reg, excess_next;
    logic           out_valid_reg, out_valid_next;

    // payload
    logic [vjb_pkg::SEQ_BITS-1:0]    seq_reg, seq_next;
    logic [HANDLE_BITS-1:0]          handle_reg, handle_next;
    logic [OW-1:0]                   off_reg, off_next;
    logic [OW-1:0]                   total_reg, total_next;
    logic [OW-1:0]                   tgt_reg, tgt_next;
    logic [OW-1:0]                   drop_reg, drop_next;
    logic [CW-1:0]                   fin_reg, fin_next;
    logic [CW-1:0]                   g_reg, g_next;
    logic [CW-1:0]                   keep_reg, keep_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [IW-1:0]                   ptr_reg, ptr_next;
    logic [IW-1:0]                   tslot_reg, tslot_next;
    logic [EW-1:0]                   fill_reg, fill_next;
    logic [vjb_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [SB-1:0]                   gaps_reg, gaps_next;
    logic [SB-1:0]                   dropn_reg, dropn_next;

    logic [vjb_pkg::STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [SB-1:0]                   out_gaps_reg, out_gaps_next;
    logic [SB-1:0]                   out_dropn_reg, out_dropn_next;
    logic [vjb_pkg::FILL_BITS-1:0]   out_fill_reg, out_fill_next;
    logic [XW-1:0]                   out_excess_reg, out_excess_next;

    // entry store
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [OW-1:0] limit;
    logic [XW:0]   excess_sum;
    logic [IW-1:0] newest_slot;
    logic [IW-1:0] tgt_slot;

    vjb_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign limit       = (OW'(max_fill_reg) > OW'(CAPACITY)) ? OW'(CAPACITY) : OW'(max_fill_reg);
    assign excess_sum  = {1'b0, excess_reg} + (XW + 1)'(drop_reg);
    assign newest_slot = wrap_idx(SW'(head_reg) + SW'(count_reg - CW'(1)));
    assign tgt_slot    = wrap_idx(SW'(head_reg) + SW'(tgt_reg[CW-1:0]));

    assign ram_we    = cmd.gap_wr | cmd.app_wr | cmd.walk_wr | cmd.fix_wr;
    assign ram_waddr = cmd.fix_wr ? tslot_reg : ptr_reg;
    assign ram_raddr = cmd.classify ? newest_slot : ptr_reg;

    always_comb
    begin
        priority if (cmd.gap_wr)
        begin
            ram_wdata = fill_reg;
        end
        else if (cmd.walk_wr)
        begin
            ram_wdata = {1'b1, 1'b0, handle_reg};
        end
        else
        begin
            ram_wdata = {1'b1, 1'b1, handle_reg};
        end
    end

    assign sts.off_pos   = !off_reg[OW-1] && (off_reg != '0);
    assign sts.fin_zero  = (fin_reg == '0);
    assign sts.g_zero    = (g_reg == '0);
    assign sts.tgt_neg   = tgt_reg[OW-1];
    assign sts.stretch   = stretch_reg;
    assign sts.walk_more = (SW'(idx_reg) + SW'(1)) < SW'(count_reg);
    assign sts.rd_valid  = ram_rdata[HANDLE_BITS];
    assign sts.out_free  = !out_valid_reg || res_ready;

    always_comb
    begin
        max_fill_next   = max_fill_reg;
        stretch_next    = stretch_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        primed_next     = primed_reg;
        excess_next     = excess_reg;
        out_valid_next  = out_valid_reg;
        seq_next        = seq_reg;
        handle_next     = handle_reg;
        off_next        = off_reg;
        total_next      = total_reg;
        tgt_next        = tgt_reg;
        drop_next       = drop_reg;
        fin_next        = fin_reg;
        g_next          = g_reg;
        keep_next       = keep_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        tslot_next      = tslot_reg;
        fill_next       = fill_reg;
        status_next     = status_reg;
        gaps_next       = gaps_reg;
        dropn_next      = dropn_reg;
        out_status_next = out_status_reg;
        out_gaps_next   = out_gaps_reg;
        out_dropn_next  = out_dropn_reg;
        out_fill_next   = out_fill_reg;
        out_excess_next = out_excess_reg;

        if (cfg_we)
        begin
            if (cfg_index == vjb_pkg::REG_MAX_FILL)
            begin
                max_fill_next = cfg_data[MW-1:0];
            end
            else if (cfg_index == vjb_pkg::REG_STRETCH)
            begin
                stretch_next = cfg_data[0];
            end
        end

        if (cmd.load)
        begin
            seq_next    = seq_in;
            handle_next = handle_in;
            if (!primed_reg)
            begin
                last_next   = LW'(seq_in) - LW'(1);
                primed_next = 1'b1;
            end
        end

        if (cmd.offs)
        begin
            off_next = OW'(seq_reg) - {{(OW - LW){last_reg[LW-1]}}, last_reg};
        end

        if (cmd.classify)
        begin
            total_next = OW'(count_reg) + off_reg;
            tgt_next   = OW'(count_reg) - OW'(1) + off_reg;
            if (sts.off_pos)
            begin
                last_next = LW'(seq_reg);
            end
        end

        if (cmd.fin)
        begin
            fin_next  = (total_reg > limit) ? CW'(limit) : CW'(total_reg);
            fill_next = (stretch_reg && (count_reg != '0)) ? (ram_rdata & FILL_MASK) : '0;
        end

        if (cmd.drop)
        begin
            drop_next = total_reg - OW'(fin_reg);
            g_next    = (off_reg < OW'(fin_reg)) ? CW'(off_reg - OW'(1)) : fin_reg - CW'(1);
        end

        if (cmd.keep)
        begin
            keep_next   = fin_reg - CW'(1) - g_reg;
            excess_next = (excess_sum > EXC_MAX) ? {XW{1'b1}} : excess_sum[XW-1:0];
            status_next = vjb_pkg::ST_APPENDED;
            gaps_next   = sat16(off_reg - OW'(1));
            dropn_next  = sat16(drop_reg);
            if (fin_reg == '0)
            begin
                head_next  = '0;
                count_next = '0;
            end
        end

        if (cmd.pop)
        begin
            if (count_reg > keep_reg)
            begin
                head_next  = wrap_idx(SW'(head_reg) + SW'(count_reg - keep_reg));
                count_next = keep_reg;
            end
        end

        if (cmd.ptr)
        begin
            ptr_next = wrap_idx(SW'(head_reg) + SW'(count_reg));
        end

        if (cmd.gap_wr)
        begin
            ptr_next   = wrap_idx(SW'(ptr_reg) + SW'(1));
            count_next = count_reg + CW'(1);
            g_next     = g_reg - CW'(1);
        end

        if (cmd.app_wr)
        begin
            count_next = count_reg + CW'(1);
        end

        if (cmd.tchk)
        begin
            status_next = tgt_reg[OW-1] ? vjb_pkg::ST_REJECTED : vjb_pkg::ST_REPAIRED;
            gaps_next   = '0;
            dropn_next  = '0;
            tslot_next  = tgt_slot;
            ptr_next    = tgt_slot;
            idx_next    = tgt_reg[CW-1:0];
        end

        if (cmd.walk_wr)
        begin
            ptr_next = wrap_idx(SW'(ptr_reg) + SW'(1));
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_gaps_next   = gaps_reg;
            out_dropn_next  = dropn_reg;
            out_fill_next   = vjb_pkg::FILL_BITS'(count_reg);
            out_excess_next = excess_reg;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fill_reg  <= vjb_pkg::MAX_FILL_RESET;
            stretch_reg   <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            last_reg      <= '0;
            primed_reg    <= 1'b0;
            excess_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_fill_reg  <= max_fill_next;
            stretch_reg   <= stretch_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            primed_reg    <= primed_next;
            excess_reg    <= excess_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg        <= seq_next;
        handle_reg     <= handle_next;
        off_reg        <= off_next;
        total_reg      <= total_next;
        tgt_reg        <= tgt_next;
        drop_reg       <= drop_next;
        fin_reg        <= fin_next;
        g_reg          <= g_next;
        keep_reg       <= keep_next;
        idx_reg        <= idx_next;
        ptr_reg        <= ptr_next;
        tslot_reg      <= tslot_next;
        fill_reg       <= fill_next;
        status_reg     <= status_next;
        gaps_reg       <= gaps_next;
        dropn_reg      <= dropn_next;
        out_status_reg <= out_status_next;
        out_gaps_reg   <= out_gaps_next;
        out_dropn_reg  <= out_dropn_next;
        out_fill_reg   <= out_fill_next;
        out_excess_reg <= out_excess_next;
    end

    assign res_valid        = out_valid_reg;
    assign res_status       = out_status_reg;
    assign res_gap_fills    = out_gaps_reg;
    assign res_dropped_now  = out_dropn_reg;
    assign res_fill_level   = out_fill_reg;
    assign res_excess_total = out_excess_reg;

endmodule

FILE: rtl/core/voice_jitter_buffer_top.sv
// Top level of the voice jitter buffer: controller, datapath and channel hookup.
//
//  channel | dir | word                                  | handshake
//  --------+-----+---------------------------------------+-------------------------
//  cfg     | in  | index, data (max_fill, stretch_enable)| valid/ready, ready held 1
//  pkt     | in  | sequence_number, packet_handle        | valid/ready
//  res     | out | status, gap_fills, dropped_now,       | valid/ready
//          |     | fill_level, excess_total              |
//
//  Append: g gap entries (at most CAPACITY - 1) are written ahead of the packet's entry,
//  one entry store write per cycle; an append under max_fill 0 writes no entry.
//  Repair: the target entry is rewritten; with stretch_enable, the walk first rewrites
//  the entries from the target towards the newest one and stops at a valid entry.
//  Rejected repair: no entry is written. Reset leaves the entry store as is; no clearing pass.
//  The result register holds one word; the next packet is taken while it waits,
//  and the block stalls at the end of that packet until the result is taken.
module voice_jitter_buffer_top #(
    parameter int CAPACITY    = vjb_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = vjb_pkg::HANDLE_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    vjb_cfg_if.sink  cfg,
    vjb_pkt_if.sink  pkt,
    vjb_res_if.source res
);

    vjb_pkg::cmd_t cmd;
    vjb_pkg::sts_t sts;
    logic          in_ready;

    assign cfg.ready = 1'b1;
    assign pkt.ready = in_ready;

    vjb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vjb_dp #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .seq_in           (pkt.sequence_number),
        .handle_in        (pkt.packet_handle),
        .res_ready        (res.ready),
        .res_valid        (res.valid),
        .res_status       (res.status),
        .res_gap_fills    (res.gap_fills),
        .res_dropped_now  (res.dropped_now),
        .res_fill_level   (res.fill_level),
        .res_excess_total (res.excess_total)
    );

endmodule

FILE: dv/vjb_result_checker.sv
// Result checker: predicts the result word of every accepted packet and compares it field by field.
module vjb_result_checker
    import vjb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vjb_cfg_if   cfg,
    vjb_pkt_if   pkt,
    vjb_res_if   res,
    output int   fail_count,
    output int   pending
);

    localparam int CAP       = CAPACITY_DEF;
    localparam int HB        = HANDLE_BITS_DEF;
    localparam int DUE_DEPTH = 4;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SAT_BITS-1:0]    gap_fills;
        logic [SAT_BITS-1:0]    dropped_now;
        logic [FILL_BITS-1:0]   fill_level;
        logic [EXCESS_BITS-1:0] excess_total;
    } outcome_t;

    // entry: [HB+1] present, [HB] valid, [HB-1:0] handle
    logic [HB+1:0]            ring [CAP];
    int                       head;
    int                       count;
    logic [LAST_BITS-1:0]     last_seq;
    bit                       primed;
    logic [EXCESS_BITS-1:0]   excess;
    logic [MAX_FILL_BITS-1:0] fill_cap;
    bit                       stretch_on;

    outcome_t due_results [DUE_DEPTH];
    int       due_rd;
    int       due_wr;
    int       due_cnt;
    outcome_t want;
    outcome_t got;
    int       errs;

    function automatic int slot(longint i);
        return int'((longint'(head) + i) % CAP);
    endfunction

    function automatic logic [SAT_BITS-1:0] sat16(longint v);
        if (v > 65535)
            return '1;
        return v[SAT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
        errs++;
    endtask

    task automatic admit_packet(input logic [SEQ_BITS-1:0] seq, input logic [HB-1:0] handle,
                                output outcome_t o);
        longint        last_s;
        longint        offset;
        longint        skipped;
        longint        total;
        longint        lim;
        longint        fin;
        longint        drop;
        longint        g;
        longint        keep;
        longint        target;
        longint        sum;
        longint        i;
        logic [HB+1:0] filler;
        o = '0;
        if (!primed)
        begin
            last_seq = {1'b0, seq} - 32'd1;
            primed   = 1'b1;
        end
        last_s = longint'($signed(last_seq));
        offset = longint'({1'b0, seq}) - last_s;
        if (offset > 0)
        begin
            skipped = offset - 1;
            total   = longint'(count) + skipped + 1;
            lim     = (fill_cap > CAP) ? longint'(CAP) : longint'(fill_cap);
            fin     = (total > lim) ? lim : total;
            drop    = total - fin;
            filler  = '0;
            if (stretch_on && count > 0)
            begin
                filler     = ring[slot(count - 1)];
                filler[HB] = 1'b0;
            end
            if (fin == 0)
            begin
                head  = 0;
                count = 0;
            end
            else
            begin
                g    = (skipped < fin - 1) ? skipped : fin - 1;
                keep = fin - 1 - g;
                while (count > keep)
                begin
                    head = (head + 1) % CAP;
                    count--;
                end
                for (i = 0; i < g; i++)
                begin
                    ring[slot(count)] = filler;
                    count++;
                end
                ring[slot(count)] = {2'b11, handle};
                count++;
            end
            sum    = longint'(excess) + drop;
            excess = (sum > 64'h0000_0000_FFFF_FFFF) ? '1 : sum[EXCESS_BITS-1:0];
            last_seq      = {1'b0, seq};
            o.status      = ST_APPENDED;
            o.gap_fills   = sat16(skipped);
            o.dropped_now = sat16(drop);
        end
        else
        begin
            target = longint'(count) - 1 + offset;
            if (target < 0)
                o.status = ST_REJECTED;
            else
            begin
                if (stretch_on)
                begin
                    for (i = target; i + 1 < count; i++)
                    begin
                        if (ring[slot(i)][HB])
                            break;
                        ring[slot(i)] = {2'b10, handle};
                    end
                end
                ring[slot(target)] = {2'b11, handle};
                o.status = ST_REPAIRED;
            end
        end
        o.fill_level   = count[FILL_BITS-1:0];
        o.excess_total = excess;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CAP; k++)
                ring[k] = '0;
            head       = 0;
            count      = 0;
            last_seq   = '0;
            primed     = 1'b0;
            excess     = '0;
            fill_cap   = MAX_FILL_RESET;
            stretch_on = 1'b0;
            errs       = 0;
            due_rd     = 0;
            due_wr     = 0;
            due_cnt    = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_MAX_FILL)
                    fill_cap = cfg.data;
                else if (cfg.index == REG_STRETCH)
                    stretch_on = cfg.data[0];
            end
            if (res.valid && res.ready)
            begin
                if (due_cnt == 0)
                    report_mismatch("result word with nothing pending, fill_level",
                                    32'(res.fill_level), 32'd0);
                else
                begin
                    want    = due_results[due_rd];
                    due_rd  = (due_rd + 1) % DUE_DEPTH;
                    due_cnt--;
                    if (res.status !== want.status)
                        report_mismatch("status", 32'(res.status), 32'(want.status));
                    if (res.gap_fills !== want.gap_fills)
                        report_mismatch("gap_fills", 32'(res.gap_fills),
                                        32'(want.gap_fills));
                    if (res.dropped_now !== want.dropped_now)
                        report_mismatch("dropped_now", 32'(res.dropped_now),
                                        32'(want.dropped_now));
                    if (res.fill_level !== want.fill_level)
                        report_mismatch("fill_level", 32'(res.fill_level),
                                        32'(want.fill_level));
                    if (res.excess_total !== want.excess_total)
                        report_mismatch("excess_total", res.excess_total, want.excess_total);
                end
            end
            if (pkt.valid && pkt.ready)
            begin
                admit_packet(pkt.sequence_number, pkt.packet_handle, got);
                if (due_cnt == DUE_DEPTH)
                    report_mismatch("result backlog overflow, fill_level",
                                    32'(got.fill_level), 32'd0);
                else
                begin
                    due_results[due_wr] = got;
                    due_wr  = (due_wr + 1) % DUE_DEPTH;
                    due_cnt++;
                end
            end
            pending    <= due_cnt;
            fail_count <= errs;
        end
    end

endmodule

FILE: dv/tb_voice_jitter_buffer_top.sv
// Testbench top: clock, reset, packet and register stimulus, result stalls and the verdict.
module tb_voice_jitter_buffer_top;
    import vjb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_PHASES = 10;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd5;

    logic clk;
    logic rst_n;

    vjb_cfg_if                                   cfg();
    vjb_pkt_if #(.HANDLE_BITS(HANDLE_BITS_DEF)) pkt();
    vjb_res_if                                   res();

    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    bit                  calm;
    logic [SEQ_BITS-1:0] newest_seq;

    voice_jitter_buffer_top #(
        .CAPACITY    (CAPACITY_DEF),
        .HANDLE_BITS (HANDLE_BITS_DEF)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pkt   (pkt),
        .res   (res)
    );

    vjb_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pkt        (pkt),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        res.ready <= calm || ($urandom_range(0, 99) >= 18);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** voice_jitter_buffer_top: FAILED **");
            $finish;
        end
    end

    task automatic send_packet(input logic [SEQ_BITS-1:0] seq,
                               input logic [HANDLE_BITS_DEF-1:0] handle);
        while (!calm && $urandom_range(0, 99) < 18)
        begin
            pkt.valid <= 1'b0;
            @(posedge clk);
        end
        pkt.valid           <= 1'b1;
        pkt.sequence_number <= seq;
        pkt.packet_handle   <= handle;
        @(posedge clk);
        while (!pkt.ready)
            @(posedge clk);
        if (seq > newest_seq)
            newest_seq = seq;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        pkt.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic [CFG_DATA_BITS-1:0] fill,
                            input logic [CFG_DATA_BITS-1:0] stretch_word);
        drain_results();
        write_reg(REG_MAX_FILL, fill);
        write_reg(REG_STRETCH, stretch_word);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        int                       r;
        int                       n_items;
        logic [CFG_DATA_BITS-1:0] fill;
        logic [CFG_DATA_BITS-1:0] stretch_word;
        longint                   nxt;
        logic [SEQ_BITS-1:0]      seq;

        rst_n               = 1'b0;
        calm                = 1'b0;
        newest_seq          = '0;
        cfg.valid           = 1'b0;
        cfg.index           = REG_MAX_FILL;
        cfg.data            = '0;
        pkt.valid           = 1'b0;
        pkt.sequence_number = '0;
        pkt.packet_handle   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first packet wraps the primed sequence, then repairs, gaps, overflow, rejects
        set_mode(7'd64, 7'd0);
        send_packet(31'd0, 16'hFFFF);
        send_packet(31'd0, 16'h0000);
        send_packet(31'd4, 16'h1234);
        send_packet(31'd2, 16'hAAAA);
        send_packet(31'd5, 16'h5555);
        send_packet(31'd0, 16'h00FF);
        send_packet(31'd200, 16'hFF00);
        send_packet(31'd150, 16'h0F0F);
        send_packet(31'd100, 16'hF0F0);

        // stretched gaps, repair walks, saturated gap count
        set_mode(7'd64, 7'd1);
        send_packet(31'd203, 16'h3C3C);
        send_packet(31'd201, 16'hC3C3);
        send_packet(31'd198, 16'h6666);
        send_packet(31'd70203, 16'h9999);

        // zero fill limit, late packet into an empty buffer
        set_mode(7'd0, 7'd0);
        send_packet(31'd70204, 16'h1111);
        send_packet(31'd70204, 16'h2222);
        send_packet(31'd70210, 16'h3333);

        // limit above capacity, stretch from an empty buffer
        set_mode(7'd127, 7'd1);
        send_packet(31'd70213, 16'h4444);
        send_packet(31'd70217, 16'h7777);
        send_packet(31'd70215, 16'h8888);

        set_mode(7'd1, 7'd1);
        send_packet(31'd70218, 16'hABCD);
        send_packet(31'd70218, 16'hDCBA);
        send_packet(31'd70222, 16'hBEEF);

        drain_results();
        write_reg(REG_UNUSED, 7'h7F);
        write_reg(REG_STRETCH, 7'h7E);
        cfg.valid <= 1'b0;
        send_packet(31'd70223, 16'h0001);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       fill = 7'd64;
                1:       fill = 7'd1;
                2:       fill = 7'd16;
                3:       fill = 7'd127;
                4:       fill = 7'd0;
                5:       fill = 7'd5;
                6:       fill = 7'd40;
                7:       fill = 7'd2;
                8:       fill = CFG_DATA_BITS'($urandom_range(1, 64));
                default: fill = 7'd64;
            endcase
            stretch_word    = CFG_DATA_BITS'($urandom_range(0, 127));
            stretch_word[0] = p[0];
            set_mode(fill, stretch_word);
            calm    = (p == 2);
            n_items = (fill == 0) ? 40 : 190;
            for (int n = 0; n < n_items; n++)
            begin
                r = $urandom_range(0, 99);
                if (p == RANDOM_PHASES - 1 && r < 30)
                    seq = SEQ_BITS'($urandom);
                else if (r < 61)
                begin
                    if (r < 50)
                        nxt = longint'($urandom_range(1, 3));
                    else if (r < 58)
                        nxt = longint'($urandom_range(4, 80));
                    else
                        nxt = longint'($urandom_range(65530, 70000));
                    nxt = nxt + longint'(newest_seq);
                    if (nxt > 64'h7FFF_FFFF)
                        seq = SEQ_BITS'($urandom);
                    else
                        seq = nxt[SEQ_BITS-1:0];
                end
                else
                begin
                    if (r < 90)
                        nxt = longint'($urandom_range(0, 70));
                    else
                        nxt = longint'($urandom_range(71, 200000));
                    if (nxt > longint'(newest_seq))
                        seq = '0;
                    else
                        seq = newest_seq - nxt[SEQ_BITS-1:0];
                end
                send_packet(seq, HANDLE_BITS_DEF'($urandom_range(0, 65535)));
            end
        end
        calm = 1'b0;

        // top of the sequence range, then far-late and duplicate packets
        send_packet(31'h7FFF_FFFF, 16'hFFFF);
        send_packet(31'd0, 16'h0000);
        send_packet(31'h7FFF_FFFF, 16'h0001);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** voice_jitter_buffer_top: PASSED **");
        else
            $display("** voice_jitter_buffer_top: FAILED **");
        $finish;
    end

endmodule
